@@ rtl/perlin_noise_3d_core_defines.svh @@
// assertion macros for the gradient noise core
`ifndef PERLIN_NOISE_3D_CORE_DEFINES_SVH
`define PERLIN_NOISE_3D_CORE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define PN3_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define PN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pn3_pkg.sv @@
// package: constants, permutation table and gradient select of the noise core
`timescale 1ns / 1ps
`default_nettype none
package pn3_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 16;
  localparam int COORD_BITS = INT_BITS + FRAC_BITS;
  localparam int COORD_W    = 32;
  localparam int NOISE_W    = 17;
  localparam int TILE_W     = 16;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam int MOD_BPS    = 2;
  localparam int MOD_STAGES = INT_BITS / MOD_BPS;

  // stage map
  localparam int S_IDX   = MOD_STAGES + 1;
  localparam int S_H1    = S_IDX + 1;
  localparam int S_H2    = S_IDX + 2;
  localparam int S_H3    = S_IDX + 3;
  localparam int S_GRAD  = S_IDX + 4;
  localparam int S_WAIT  = S_IDX + 5;
  localparam int S_XMUL  = S_IDX + 6;
  localparam int S_XADD  = S_IDX + 7;
  localparam int S_YMUL  = S_IDX + 8;
  localparam int S_YADD  = S_IDX + 9;
  localparam int S_ZMUL  = S_IDX + 10;
  localparam int S_OUT   = S_IDX + 11;
  localparam int NSTG    = S_OUT + 1;
  localparam int FADE_STAGES = 6;

  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int GRAD_W = FRAC_BITS + 3;
  localparam int LRP_W  = FRAC_BITS + 4;
  localparam int DIF_W  = LRP_W + 1;
  localparam int PRD_W  = DIF_W + WGT_W + 1;

  localparam logic [NOISE_W-1:0] NOISE_MAX = NOISE_W'(65536);

  localparam logic [PADDR_W-1:0] REG_TILE_PERIOD = '0;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,
    8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,
    8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,
    8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,
    8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,
    8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,
    8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,
    8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,
    8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,
    8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
    8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,
    8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,
    8'd61,8'd156,8'd180
  };

  function automatic logic signed [GRAD_W-1:0] grad_dot(
    input logic [3:0]               h,
    input logic signed [GRAD_W-1:0] x,
    input logic signed [GRAD_W-1:0] y,
    input logic signed [GRAD_W-1:0] z
  );
    logic signed [GRAD_W-1:0] g;
    case (h)
      4'd0:    g =  x + y;
      4'd1:    g = -x + y;
      4'd2:    g =  x - y;
      4'd3:    g = -x - y;
      4'd4:    g =  x + z;
      4'd5:    g = -x + z;
      4'd6:    g =  x - z;
      4'd7:    g = -x - z;
      4'd8:    g =  y + z;
      4'd9:    g = -y + z;
      4'd10:   g =  y - z;
      4'd11:   g = -y - z;
      4'd12:   g =  y + x;
      4'd13:   g = -y + z;
      4'd14:   g =  y - x;
      default: g = -y - z;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pn3_if.sv @@
// stream interfaces: coordinate transaction in, noise transaction out
`timescale 1ns / 1ps
`default_nettype none
interface pn3_coord_if import pn3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface pn3_noise_if import pn3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

@@ rtl/pn3_fade.sv @@
// six-stage fade curve 6t^5-15t^4+10t^3 for one axis
`timescale 1ns / 1ps
`default_nettype none
module pn3_fade import pn3_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic [FADE_STAGES-1:0] en_i,
  input  wire logic [FRAC_BITS-1:0]   frac_i,
  output      logic [WGT_W-1:0]       weight_o
);

  localparam int PW = 2 * FRAC_BITS;
  localparam int VW = 2 * FRAC_BITS + 6;
  localparam int QW = VW - FRAC_BITS;
  localparam int MW = WGT_W + FRAC_BITS;
  localparam int M2W = WGT_W + QW;
  localparam logic [VW-1:0] TEN_TT = VW'(10) << (2 * FRAC_BITS);
  localparam logic [VW-1:0] HALF_V = VW'(1) << (FRAC_BITS - 1);
  localparam logic [M2W-1:0] HALF_M2 = M2W'(1) << (FRAC_BITS - 1);
  localparam logic [MW-1:0] HALF_M = MW'(1) << (FRAC_BITS - 1);
  localparam logic [PW:0] HALF_P = (PW+1)'(1) << (FRAC_BITS - 1);

  logic [PW-1:0]        p_q;
  logic [FRAC_BITS-1:0] f1_q, f2_q;
  logic [WGT_W-1:0]     t2_q, t3_q;
  logic [QW-1:0]        q2_q, q3_q, q4_q;
  logic [MW-1:0]        m_q;
  logic [M2W-1:0]       m2_q;
  logic [WGT_W-1:0]     w_q;

  logic [VW-1:0] q_sum;
  logic [PW:0]   t2_sum;
  logic [MW-1:0] m_sum;
  logic [M2W-1:0] m2_sum;

  always_comb begin
    q_sum  = (VW'(p_q) << 2) + (VW'(p_q) << 1) + TEN_TT
           - (VW'(15) * VW'(f1_q) << FRAC_BITS) + HALF_V;
    t2_sum = (PW+1)'(p_q) + HALF_P;
    m_sum  = m_q + HALF_M;
    m2_sum = m2_q + HALF_M2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q  <= PW'(frac_i) * PW'(frac_i);
      f1_q <= frac_i;
    end
    if (en_i[1]) begin
      t2_q <= WGT_W'(t2_sum >> FRAC_BITS);
      q2_q <= QW'(q_sum >> FRAC_BITS);
      f2_q <= f1_q;
    end
    if (en_i[2]) begin
      m_q  <= MW'(t2_q) * MW'(f2_q);
      q3_q <= q2_q;
    end
    if (en_i[3]) begin
      t3_q <= WGT_W'(m_sum >> FRAC_BITS);
      q4_q <= q3_q;
    end
    if (en_i[4]) begin
      m2_q <= M2W'(t3_q) * M2W'(q4_q);
    end
    if (en_i[5]) begin
      w_q <= WGT_W'(m2_sum >> FRAC_BITS);
    end
  end

  assign weight_o = w_q;

endmodule
`default_nettype wire

@@ rtl/perlin_noise_3d_core.sv @@
// top level of the 3d gradient noise core
`timescale 1ns / 1ps
`default_nettype none
// Takes one point (x, y, z in unsigned Q16.16) per transaction and returns the improved
// gradient noise at that point, mapped to [0,1] as unsigned Q1.16. The pipeline is 21
// register stages deep and takes one point every clock unless the output stalls. After
// the input register, eight stages reduce the integer parts modulo tile_period two
// quotient bits at a time; the rest run the hash lookups, the fade curve and the three
// lerp levels, one multiplier level per stage. A stalled output holds its result while
// bubbles further up still fill. tile_period (address 0) is to be written over the
// APB-style port only while idle (the core does not check this); 0 switches tiling off.
`include "perlin_noise_3d_core_defines.svh"
module perlin_noise_3d_core import pn3_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  pn3_coord_if.sink               coord_i,
  pn3_noise_if.source             noise_o
);

  localparam logic signed [GRAD_W-1:0] ONE_G = GRAD_W'(1) << FRAC_BITS;
  localparam logic signed [PRD_W-1:0]  HALF_PRD = PRD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [LRP_W:0]    ONE_R = (LRP_W+1)'(1) << FRAC_BITS;
  localparam logic signed [LRP_W:0]    TWO_R = (LRP_W+1)'(2) << FRAC_BITS;
  localparam int SCL_W = FRAC_BITS + 2 + 16 + 2;

  // configuration
  logic [TILE_W-1:0] tile_q;
  logic              cfg_wr;
  logic              tile_on;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite &&
                   (paddr[PADDR_W-1:2] == REG_TILE_PERIOD[PADDR_W-1:2]);
  assign prdata  = (paddr[PADDR_W-1:2] == REG_TILE_PERIOD[PADDR_W-1:2]) ?
                   PDATA_W'(tile_q) : '0;
  assign tile_on = (tile_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q <= '0;
    end else if (cfg_wr) begin
      tile_q <= pwdata[TILE_W-1:0];
    end
  end

  // stage valids and enables
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || noise_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign coord_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= coord_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // capture and modulo reduction
  logic [INT_BITS-1:0]  int_q  [MOD_STAGES+1][3];
  logic [INT_BITS-1:0]  rem_q  [MOD_STAGES+1][3];
  logic [FRAC_BITS-1:0] frac_q [MOD_STAGES+1][3];
  logic [COORD_W-1:0]   cin    [3];

  assign cin[0] = coord_i.coord_x;
  assign cin[1] = coord_i.coord_y;
  assign cin[2] = coord_i.coord_z;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        int_q[0][a]  <= cin[a][COORD_BITS-1:FRAC_BITS];
        frac_q[0][a] <= cin[a][FRAC_BITS-1:0];
        rem_q[0][a]  <= '0;
      end
    end
  end

  for (genvar s = 1; s <= MOD_STAGES; s++) begin : g_mod
    logic [INT_BITS:0] rr [3][MOD_BPS+1];
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        rr[a][0] = {1'b0, rem_q[s-1][a]};
        for (int j = 0; j < MOD_BPS; j++) begin
          rr[a][j+1] = {rr[a][j][INT_BITS-1:0],
                        int_q[s-1][a][INT_BITS-1-((s-1)*MOD_BPS+j)]};
          if (rr[a][j+1] >= {1'b0, tile_q}) begin
            rr[a][j+1] = rr[a][j+1] - {1'b0, tile_q};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        for (int a = 0; a < 3; a++) begin
          int_q[s][a]  <= int_q[s-1][a];
          frac_q[s][a] <= frac_q[s-1][a];
          rem_q[s][a]  <= rr[a][MOD_BPS][INT_BITS-1:0];
        end
      end
    end
  end

  // cell indices
  logic [INT_BITS-1:0] ci [3];
  logic [8:0]          inc [3];
  logic [7:0]          i0_q [3];
  logic [7:0]          i1_q [3];
  logic [FRAC_BITS-1:0] f_q [S_GRAD-S_IDX][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ci[a]  = tile_on ? rem_q[MOD_STAGES][a] : int_q[MOD_STAGES][a];
      inc[a] = {1'b0, ci[a][7:0]} + 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_IDX]) begin
      for (int a = 0; a < 3; a++) begin
        i0_q[a] <= ci[a][7:0];
        if (tile_on && (TILE_W'(inc[a]) == tile_q)) begin
          i1_q[a] <= '0;
        end else begin
          i1_q[a] <= inc[a][7:0];
        end
        f_q[0][a] <= frac_q[MOD_STAGES][a];
      end
    end
    for (int s = 1; s < S_GRAD - S_IDX; s++) begin
      if (en[S_IDX+s]) begin
        f_q[s] <= f_q[s-1];
      end
    end
  end

  // fade weights
  logic [WGT_W-1:0] wgt [3];

  for (genvar a = 0; a < 3; a++) begin : g_fade
    pn3_fade u_fade (
      .clk_i    (clk_i),
      .en_i     (en[S_IDX +: FADE_STAGES]),
      .frac_i   (frac_q[MOD_STAGES][a]),
      .weight_o (wgt[a])
    );
  end

  // hashing
  logic [7:0] iy0_q [2], iz0_q [2], iz1_q [2];
  logic [7:0] h1_q [2];
  logic [7:0] h2_q [2][2];
  logic [7:0] h3_q [2][2][2];

  always_ff @(posedge clk_i) begin
    if (en[S_H1]) begin
      h1_q[0]  <= PERM[i0_q[0]];
      h1_q[1]  <= PERM[i1_q[0]];
      iy0_q[0] <= i0_q[1];
      iy0_q[1] <= i1_q[1];
      iz0_q[0] <= i0_q[2];
      iz0_q[1] <= i1_q[2];
    end
    if (en[S_H2]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          h2_q[j][k] <= PERM[8'(h1_q[j] + iy0_q[k])];
        end
      end
      iz1_q <= iz0_q;
    end
    if (en[S_H3]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          h3_q[j][k][0] <= PERM[8'(h2_q[j][k] + iz1_q[0])];
          h3_q[j][k][1] <= PERM[8'(h2_q[j][k] + iz1_q[1])];
        end
      end
    end
  end

  // gradients
  logic signed [GRAD_W-1:0] d [3][2];
  logic signed [GRAD_W-1:0] g_q  [2][2][2];
  logic signed [GRAD_W-1:0] gw_q [2][2][2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d[a][0] = $signed(GRAD_W'(f_q[S_GRAD-S_IDX-1][a]));
      d[a][1] = d[a][0] - ONE_G;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_GRAD]) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 2; k++) begin
          for (int l = 0; l < 2; l++) begin
            g_q[j][k][l] <= grad_dot(h3_q[j][k][l][3:0], d[0][j], d[1][k], d[2][l]);
          end
        end
      end
    end
    if (en[S_WAIT]) begin
      gw_q <= g_q;
    end
  end

  // trilinear blend
  logic [WGT_W-1:0]          wy_q [2], wz_q [4];
  logic signed [LRP_W-1:0]   xa_q [2][2];
  logic signed [PRD_W-1:0]   xp_q [2][2];
  logic signed [LRP_W-1:0]   lx_q [2][2];
  logic signed [LRP_W-1:0]   ya_q [2];
  logic signed [PRD_W-1:0]   yp_q [2];
  logic signed [LRP_W-1:0]   ly_q [2];
  logic signed [LRP_W-1:0]   za_q;
  logic signed [PRD_W-1:0]   zp_q;
  logic [NOISE_W-1:0]        noise_q;

  function automatic logic signed [PRD_W-1:0] wmul(
    input logic [WGT_W-1:0]      w,
    input logic signed [DIF_W-1:0] df
  );
    return $signed(PRD_W'(w)) * $signed(PRD_W'(df));
  endfunction

  function automatic logic signed [LRP_W-1:0] wrnd(
    input logic signed [LRP_W-1:0] a,
    input logic signed [PRD_W-1:0] p
  );
    logic signed [PRD_W-1:0] s;
    s = (p + HALF_PRD) >>> FRAC_BITS;
    return a + LRP_W'(s);
  endfunction

  logic signed [LRP_W:0]  rsum;
  logic [LRP_W:0]         rsat;
  logic [SCL_W-1:0]       scl;

  always_comb begin
    rsum = (LRP_W+1)'(wrnd(za_q, zp_q)) + ONE_R;
    if (rsum < 0) begin
      rsat = '0;
    end else if (rsum > TWO_R) begin
      rsat = TWO_R;
    end else begin
      rsat = rsum;
    end
    scl = (SCL_W'(rsat) << 16) + (SCL_W'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en[S_XMUL]) begin
      for (int k = 0; k < 2; k++) begin
        for (int l = 0; l < 2; l++) begin
          xa_q[k][l] <= LRP_W'(gw_q[0][k][l]);
          xp_q[k][l] <= wmul(wgt[0], DIF_W'(gw_q[1][k][l]) - DIF_W'(gw_q[0][k][l]));
        end
      end
      wy_q[0] <= wgt[1];
      wz_q[0] <= wgt[2];
    end
    if (en[S_XADD]) begin
      for (int k = 0; k < 2; k++) begin
        for (int l = 0; l < 2; l++) begin
          lx_q[k][l] <= wrnd(xa_q[k][l], xp_q[k][l]);
        end
      end
      wy_q[1] <= wy_q[0];
      wz_q[1] <= wz_q[0];
    end
    if (en[S_YMUL]) begin
      for (int l = 0; l < 2; l++) begin
        ya_q[l] <= lx_q[0][l];
        yp_q[l] <= wmul(wy_q[1], DIF_W'(lx_q[1][l]) - DIF_W'(lx_q[0][l]));
      end
      wz_q[2] <= wz_q[1];
    end
    if (en[S_YADD]) begin
      for (int l = 0; l < 2; l++) begin
        ly_q[l] <= wrnd(ya_q[l], yp_q[l]);
      end
      wz_q[3] <= wz_q[2];
    end
    if (en[S_ZMUL]) begin
      za_q <= ly_q[0];
      zp_q <= wmul(wz_q[3], DIF_W'(ly_q[1]) - DIF_W'(ly_q[0]));
    end
    if (en[S_OUT]) begin
      noise_q <= scl[FRAC_BITS+1 +: NOISE_W];
    end
  end

  assign noise_o.valid       = v_q[NSTG-1];
  assign noise_o.noise_value = noise_q;

  `PN3_ASSERT_NOW(a_noise_range, !noise_o.valid || (noise_o.noise_value <= NOISE_MAX), "noise out of range")
  `PN3_ASSERT_NEXT(a_accept_enters, coord_i.valid && coord_i.ready, v_q[0], "accepted transaction lost")
  `PN3_ASSERT_NEXT(a_cfg_write, cfg_wr, tile_q == $past(pwdata[TILE_W-1:0]), "tile period not written")

endmodule
`default_nettype wire
